>>> sv/rlfp_pkg.sv
// Shared constants, types and helper functions of the RC link frame parser.
package rlfp_pkg;

  // Frame store depth and number of channels in a channels frame
  localparam int MAX_FRAME_BYTES = 64;
  localparam int CHANNEL_COUNT   = 16;

  // Derived widths
  localparam int ADDR_W     = $clog2(MAX_FRAME_BYTES);
  localparam int POS_W      = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CH_BITS    = 11;
  localparam int BUF_W      = CH_BITS + 8;
  localparam int NBITS_W    = $clog2(BUF_W + 1);
  localparam int READ_BYTES = (CHANNEL_COUNT * CH_BITS + 7) / 8;
  localparam int RDK_W      = $clog2(READ_BYTES + 1);
  localparam int PAYLOAD_START = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHTYPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd2;

  // Register reset values
  localparam logic [7:0] SYNC_RESET   = 8'hC8;
  localparam logic [7:0] CHTYPE_RESET = 8'h16;
  localparam logic [6:0] LIMIT_RESET  = 7'd64;

  // Result status codes
  localparam logic [1:0] STAT_CHANNEL = 2'd0;
  localparam logic [1:0] STAT_OTHER   = 2'd1;
  localparam logic [1:0] STAT_CRC     = 2'd2;
  localparam logic [1:0] STAT_LENGTH  = 2'd3;

  // CRC-8 (DVB-S2)
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Pulse range of a channel result
  localparam logic [11:0] PULSE_MIN = 12'd880;
  localparam logic [11:0] PULSE_MAX = 12'd2159;

  typedef enum logic [0:0] {P_IDLE, P_UNPACK} parse_state_t;
  typedef enum logic [1:0] {U_IDLE, U_READ, U_APPEND, U_EMIT} unpack_state_t;

  // Start request to the channel unpacker
  typedef struct packed {
    logic       start;
    logic [7:0] plen;
  } unpack_ctl_t;

  // Channel beat offered by the unpacker
  typedef struct packed {
    logic        valid;
    logic [3:0]  index;
    logic [11:0] pulse;
    logic        last;
    logic        busy;
  } unpack_res_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // Map a raw channel to ((raw-992)*5>>3)+1500 on a non-negative offset
  function automatic logic [11:0] to_pulse(input logic [CH_BITS-1:0] raw);
    logic [13:0] t;
    t = (14'(raw) << 2) + 14'(raw) + 14'd3040;
    return 12'(t >> 3) + 12'd500;
  endfunction

endpackage

>>> sv/rlfp_if.sv
// Handshake interfaces of the received byte and result channels.
interface rlfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rlfp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  frame_type;
  logic [3:0]  channel_index;
  logic [11:0] pulse_width;
  logic        last;

  modport source (output valid, output status, output frame_type, output channel_index,
                  output pulse_width, output last, input ready);
  modport sink (input valid, input status, input frame_type, input channel_index,
                input pulse_width, input last, output ready);
endinterface

>>> sv/rc_link_frame_parser.sv
// Top level of the RC link frame parser: framing, CRC check, frame store and result register.
//
// The parser takes one received byte per cycle while it hunts, reads the length and collects
// a frame; the CRC-8 of the type and payload bytes is folded in the cycle each arrives, and
// each byte from the type byte on, the CRC byte included, is written to the frame store RAM.
// A finished frame with a bad CRC, of another type, or a bad length byte gives one result beat
// at once. A good channels frame starts the unpacker, which reads the payload and the CRC byte
// back through the store's single registered read port; no byte is taken during that run. A
// result beat waits in an output register, and while it waits no byte is taken unless the
// result side takes the beat in the same cycle. The frame store needs no clearing after reset.
module rc_link_frame_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rlfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlfp_pkg::CFG_DATA_W-1:0] cfg_data,
  rlfp_rx_if.sink                         rx,
  rlfp_res_if.source                      res
);

  rlfp_pkg::parse_state_t pstate, pstate_next;

  // Configuration registers
  logic [7:0] sync_value;
  logic [7:0] channels_type;
  logic [6:0] frame_size_limit;

  // Framing state
  logic [rlfp_pkg::POS_W-1:0] pos, pos_next;
  logic [7:0] dl, dl_next;
  logic [7:0] crc, crc_next;
  logic [7:0] ftype, ftype_next;

  // Result register
  logic        res_valid;
  logic [1:0]  res_status;
  logic [7:0]  res_type;
  logic [3:0]  res_ch;
  logic [11:0] res_pw;
  logic        res_last;
  logic        ld;
  logic [1:0]  ld_status;
  logic [7:0]  ld_type;
  logic [3:0]  ld_ch;
  logic [11:0] ld_pw;
  logic        ld_last;

  logic        in_acc;
  logic        out_free;
  logic [8:0]  lim9;
  logic        len_ok;
  logic        complete;
  logic        ram_we;
  logic [7:0]  ram_rdata;
  logic [rlfp_pkg::ADDR_W-1:0] ram_raddr;
  logic        uack;
  rlfp_pkg::unpack_ctl_t uctl;
  rlfp_pkg::unpack_res_t ures;

  assign out_free = !res_valid || res.ready;
  assign rx.ready = (pstate == rlfp_pkg::P_IDLE) && out_free;
  assign in_acc   = rx.valid && rx.ready;
  assign uack     = (pstate == rlfp_pkg::P_UNPACK) && out_free;

  // Length check against the limit, clipped to the store depth
  assign lim9 = (9'(frame_size_limit) > 9'(rlfp_pkg::MAX_FRAME_BYTES)) ?
                9'(rlfp_pkg::MAX_FRAME_BYTES) : 9'(frame_size_limit);
  assign len_ok = (lim9 >= 9'd4) && (rx.rx_byte >= 8'd2) &&
                  (9'(rx.rx_byte) <= lim9 - 9'd2);

  // The byte at this position is the received CRC
  assign complete = 9'(pos) >= 9'(dl) + 9'd1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value       <= rlfp_pkg::SYNC_RESET;
      channels_type    <= rlfp_pkg::CHTYPE_RESET;
      frame_size_limit <= rlfp_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlfp_pkg::REG_SYNC:   sync_value       <= cfg_data;
        rlfp_pkg::REG_CHTYPE: channels_type    <= cfg_data;
        rlfp_pkg::REG_LIMIT:  frame_size_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Framing state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= rlfp_pkg::P_IDLE;
      pos    <= '0;
      dl     <= '0;
      crc    <= '0;
    end else begin
      pstate <= pstate_next;
      pos    <= pos_next;
      dl     <= dl_next;
      crc    <= crc_next;
    end
    ftype <= ftype_next;
  end

  // Next state, store writes and result loads
  always_comb begin
    pstate_next = pstate;
    pos_next    = pos;
    dl_next     = dl;
    crc_next    = crc;
    ftype_next  = ftype;
    ram_we      = 1'b0;
    ld          = 1'b0;
    ld_status   = rlfp_pkg::STAT_OTHER;
    ld_type     = ftype;
    ld_ch       = '0;
    ld_pw       = '0;
    ld_last     = 1'b1;
    uctl.start  = 1'b0;
    uctl.plen   = dl - 8'd1;
    unique case (pstate)
      rlfp_pkg::P_IDLE: begin
        if (in_acc) begin
          if (pos == '0) begin
            if (rx.rx_byte == sync_value) begin
              pos_next = rlfp_pkg::POS_W'(1);
            end
          end else if (pos == rlfp_pkg::POS_W'(1)) begin
            if (len_ok) begin
              dl_next  = rx.rx_byte;
              crc_next = '0;
              pos_next = rlfp_pkg::POS_W'(2);
            end else begin
              pos_next  = '0;
              ld        = 1'b1;
              ld_status = rlfp_pkg::STAT_LENGTH;
              ld_type   = '0;
            end
          end else begin
            ram_we = 1'b1;
            if (pos == rlfp_pkg::POS_W'(2)) begin
              ftype_next = rx.rx_byte;
            end
            if (!complete) begin
              pos_next = pos + 1'b1;
              crc_next = rlfp_pkg::crc8_update(crc, rx.rx_byte);
            end else begin
              pos_next = '0;
              if (crc != rx.rx_byte) begin
                ld        = 1'b1;
                ld_status = rlfp_pkg::STAT_CRC;
              end else if (ftype == channels_type) begin
                uctl.start  = 1'b1;
                pstate_next = rlfp_pkg::P_UNPACK;
              end else begin
                ld = 1'b1;
              end
            end
          end
        end
      end
      rlfp_pkg::P_UNPACK: begin
        if (ures.valid && uack) begin
          ld        = 1'b1;
          ld_status = rlfp_pkg::STAT_CHANNEL;
          ld_ch     = ures.index;
          ld_pw     = ures.pulse;
          ld_last   = ures.last;
          if (ures.last) begin
            pstate_next = rlfp_pkg::P_IDLE;
          end
        end
      end
      default: pstate_next = rlfp_pkg::P_IDLE;
    endcase
  end

  // Hold a result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ld) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (ld) begin
      res_status <= ld_status;
      res_type   <= ld_type;
      res_ch     <= ld_ch;
      res_pw     <= ld_pw;
      res_last   <= ld_last;
    end
  end

  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.frame_type    = res_type;
  assign res.channel_index = res_ch;
  assign res.pulse_width   = res_pw;
  assign res.last          = res_last;

  // Frame store
  rlfp_ram #(
    .WIDTH (8),
    .DEPTH (rlfp_pkg::MAX_FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos[rlfp_pkg::ADDR_W-1:0]),
    .wdata (rx.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Channel unpacker
  rlfp_unpack u_unpack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (uctl),
    .ack   (uack),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .res   (ures)
  );

`ifndef SYNTH
  a_status_beat_single: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != rlfp_pkg::STAT_CHANNEL |->
      res.last && res.channel_index == 4'd0 && res.pulse_width == 12'd0)
    else $error("status beat with channel fields set or not last");
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == rlfp_pkg::STAT_CHANNEL |->
      res.pulse_width >= rlfp_pkg::PULSE_MIN && res.pulse_width <= rlfp_pkg::PULSE_MAX)
    else $error("channel pulse out of range");
  a_no_byte_while_unpacking: assert property (@(posedge clk) disable iff (rst)
    ures.busy |-> !rx.ready)
    else $error("byte taken while the frame store is being read");
`endif

endmodule

>>> sv/rlfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rlfp_unpack.sv
// Channel unpacker: reads payload bytes from the frame store and emits converted channels.
module rlfp_unpack (
  input  logic                        clk,
  input  logic                        rst,
  input  rlfp_pkg::unpack_ctl_t       ctl,
  input  logic                        ack,
  output logic [rlfp_pkg::ADDR_W-1:0] raddr,
  input  logic [7:0]                  rdata,
  output rlfp_pkg::unpack_res_t       res
);

  rlfp_pkg::unpack_state_t ustate, ustate_next;
  logic [7:0]                   plen, plen_next;
  logic [rlfp_pkg::RDK_W-1:0]   rd_k, rd_k_next;
  logic [rlfp_pkg::NBITS_W-1:0] nbits, nbits_next;
  logic [rlfp_pkg::BUF_W-1:0]   bitbuf, bitbuf_next;
  logic [3:0]                   ch, ch_next;
  logic [7:0]                   pbyte;
  logic                         have_ch;

  // Address the next payload byte
  assign raddr = rlfp_pkg::ADDR_W'(rlfp_pkg::PAYLOAD_START + int'(rd_k));

  // Bytes past the received payload and its CRC byte read as zero
  assign pbyte   = (9'(rd_k) < 9'(plen)) ? rdata : 8'd0;
  assign have_ch = nbits >= rlfp_pkg::NBITS_W'(rlfp_pkg::CH_BITS);

  // Channel beat
  assign res.valid = (ustate == rlfp_pkg::U_EMIT) && have_ch;
  assign res.index = ch;
  assign res.pulse = rlfp_pkg::to_pulse(bitbuf[rlfp_pkg::CH_BITS-1:0]);
  assign res.last  = ch == 4'(rlfp_pkg::CHANNEL_COUNT - 1);
  assign res.busy  = ustate != rlfp_pkg::U_IDLE;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= rlfp_pkg::U_IDLE;
    end else begin
      ustate <= ustate_next;
    end
    plen   <= plen_next;
    rd_k   <= rd_k_next;
    nbits  <= nbits_next;
    bitbuf <= bitbuf_next;
    ch     <= ch_next;
  end

  // Read, append, emit sequence
  always_comb begin
    ustate_next = ustate;
    plen_next   = plen;
    rd_k_next   = rd_k;
    nbits_next  = nbits;
    bitbuf_next = bitbuf;
    ch_next     = ch;
    unique case (ustate)
      rlfp_pkg::U_IDLE: begin
        if (ctl.start) begin
          plen_next   = ctl.plen;
          rd_k_next   = '0;
          nbits_next  = '0;
          bitbuf_next = '0;
          ch_next     = '0;
          ustate_next = rlfp_pkg::U_READ;
        end
      end
      rlfp_pkg::U_READ: begin
        ustate_next = rlfp_pkg::U_APPEND;
      end
      rlfp_pkg::U_APPEND: begin
        bitbuf_next = bitbuf | (rlfp_pkg::BUF_W'(pbyte) << nbits);
        nbits_next  = nbits + rlfp_pkg::NBITS_W'(8);
        rd_k_next   = rd_k + 1'b1;
        ustate_next = rlfp_pkg::U_EMIT;
      end
      rlfp_pkg::U_EMIT: begin
        if (!have_ch) begin
          ustate_next = rlfp_pkg::U_READ;
        end else if (ack) begin
          bitbuf_next = bitbuf >> rlfp_pkg::CH_BITS;
          nbits_next  = nbits - rlfp_pkg::NBITS_W'(rlfp_pkg::CH_BITS);
          ch_next     = ch + 1'b1;
          ustate_next = res.last ? rlfp_pkg::U_IDLE : rlfp_pkg::U_READ;
        end
      end
      default: ustate_next = rlfp_pkg::U_IDLE;
    endcase
  end

`ifndef SYNTH
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    res.valid && ack && res.last |=> ustate == rlfp_pkg::U_IDLE)
    else $error("unpacker did not stop after the last channel");
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    ustate != rlfp_pkg::U_IDLE |-> nbits < rlfp_pkg::NBITS_W'(rlfp_pkg::BUF_W))
    else $error("unpacker bit buffer overflow");
`endif

endmodule
